// ===== rtl/core/bsmg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set min gap package
// Shared widths, reset values, request and result types, and back state codes.
// ----------------------------------------------------------------------------
package bsmg_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 9;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;
    localparam logic [VAL_W-1:0] GAP_RESET = '1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             accept;
        logic [CNT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic             status;
        logic             spans_valid;
        logic [VAL_W-1:0] shortest_span;
        logic [VAL_W-1:0] longest_span;
        logic [CNT_W-1:0] stored_count;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

endpackage

// ===== rtl/core/bsmg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set min gap front end
// Holds the capacity register, admits or rejects each request and assigns
// the store slot of every admitted value.
// ----------------------------------------------------------------------------
module bsmg_front
    import bsmg_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_push,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_req             o_req
);

    localparam int LIMIT_MAX = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_adm_cnt;
    logic [CNT_W-1:0] limit;
    logic             admit;

    assign limit    = (r_cap > CNT_W'(LIMIT_MAX)) ? CNT_W'(LIMIT_MAX) : r_cap;
    assign admit    = r_adm_cnt < limit;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_req.value  = i_value;
        o_req.accept = admit;
        o_req.slot   = r_adm_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_adm_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (o_q_push && admit) begin
                r_adm_cnt <= r_adm_cnt + CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/bsmg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set min gap request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bsmg_queue
    import bsmg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output t_req o_data,
    output logic o_empty
);

    t_req       r_ent [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/bsmg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set min gap back end
// For an admitted value, scans the earlier stored values to lower the smallest
// gap, stores the value and updates the extremes; registers every result.
// ----------------------------------------------------------------------------
module bsmg_back
    import bsmg_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  logic    i_req_vld,
    output logic    o_req_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int LIMIT_MAX = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;
    localparam int AW        = $clog2(LIMIT_MAX);

    logic [VAL_W-1:0] r_mem [LIMIT_MAX];

    t_state           r_state;
    t_state           n_state;
    t_req             r_cur;
    logic [AW-1:0]    r_rd_ptr;
    logic             r_rd_vld;
    logic [VAL_W-1:0] r_rd_data;
    logic             r_dist_vld;
    logic [VAL_W-1:0] r_dist;
    logic [VAL_W-1:0] r_gap;
    logic [VAL_W-1:0] r_min;
    logic [VAL_W-1:0] r_max;
    logic [CNT_W-1:0] r_count;
    t_result          r_out;
    logic             r_out_vld;

    logic             scan_last;
    logic             load_out;
    logic             commit;
    logic             new_lt;
    logic             spans_ok;

    assign scan_last = CNT_W'(r_rd_ptr) == (r_cur.slot - CNT_W'(1));
    assign load_out  = (r_state == S_DONE) && (!r_out_vld || i_pop);
    assign commit    = r_state == S_COMMIT;
    assign o_req_pop = (r_state == S_IDLE) && i_req_vld;
    assign new_lt    = $signed(r_cur.value) < $signed(r_rd_data);
    assign spans_ok  = r_count >= CNT_W'(2);
    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    if (!i_req.accept) begin
                        n_state = S_DONE;
                    end else if (i_req.slot == '0) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !r_dist_vld) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_ptr];
        if (commit) begin
            r_mem[r_cur.slot[AW-1:0]] <= r_cur.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_cur <= i_req;
        end
        r_dist <= new_lt ? (r_rd_data - r_cur.value) : (r_cur.value - r_rd_data);
        if (load_out) begin
            r_out.status        <= !r_cur.accept;
            r_out.spans_valid   <= spans_ok;
            r_out.shortest_span <= spans_ok ? r_gap : '0;
            r_out.longest_span  <= spans_ok ? (r_max - r_min) : '0;
            r_out.stored_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_ptr   <= '0;
            r_rd_vld   <= 1'b0;
            r_dist_vld <= 1'b0;
            r_gap      <= GAP_RESET;
            r_min      <= '0;
            r_max      <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= r_state == S_SCAN;
            r_dist_vld <= r_rd_vld;
            if (r_state == S_SCAN) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end else begin
                r_rd_ptr <= '0;
            end
            if (r_dist_vld && (r_dist < r_gap)) begin
                r_gap <= r_dist;
            end
            if (commit) begin
                r_count <= r_cur.slot + CNT_W'(1);
                if (r_cur.slot == '0) begin
                    r_min <= r_cur.value;
                    r_max <= r_cur.value;
                end else begin
                    if ($signed(r_cur.value) < $signed(r_min)) begin
                        r_min <= r_cur.value;
                    end
                    if ($signed(r_max) < $signed(r_cur.value)) begin
                        r_max <= r_cur.value;
                    end
                end
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/bounded_set_min_gap_and_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set with minimum gap and range
// Collects signed values up to a capacity and reports the smallest gap
// between any two stored values and the span from minimum to maximum.
// ----------------------------------------------------------------------------
// Requests enter through push/full and carry one signed value each. Every
// request gives exactly one result, read through empty/pop in request order.
// The user must write the capacity register (i_cfg_we, i_cfg_wdata) only while
// the block is idle, which it does not enforce; values above MAX_ENTRIES act
// as MAX_ENTRIES. A front end admits or rejects each request against the
// capacity and passes it through a two-entry queue to the back end. For a
// value stored in slot n the back end reads the n earlier values from the
// store, one per cycle on a single read port. The back end works on one
// request at a time and takes the next waiting request only after the
// previous result has been loaded.
// Reset empties the set, the queue and the result register, and sets
// the capacity to 256. When the receiver stalls the result register holds,
// the back end waits, and full rises once the queue has two requests.
// ----------------------------------------------------------------------------
module bounded_set_min_gap_and_range
    import bsmg_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [VAL_W-1:0] i_value,
    output logic             empty,
    input  logic             pop,
    output logic             o_status,
    output logic             o_spans_valid,
    output logic [VAL_W-1:0] o_shortest_span,
    output logic [VAL_W-1:0] o_longest_span,
    output logic [CNT_W-1:0] o_stored_count
);

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_req    front_req;
    t_req    back_req;
    t_result result;

    assign full = q_full;

    bsmg_front #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_push     (push),
        .i_value    (i_value),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_req      (front_req)
    );

    bsmg_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (front_req),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (back_req),
        .o_empty(q_empty)
    );

    bsmg_back #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (back_req),
        .i_req_vld(!q_empty),
        .o_req_pop(q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    assign o_status        = result.status;
    assign o_spans_valid   = result.spans_valid;
    assign o_shortest_span = result.shortest_span;
    assign o_longest_span  = result.longest_span;
    assign o_stored_count  = result.stored_count;

    a_invalid_spans_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_spans_valid) |-> (o_shortest_span == '0 && o_longest_span == '0))
        else $error("Invalid spans are not zero.");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_spans_valid == (o_stored_count >= CNT_W'(2))))
        else $error("Span valid flag disagrees with the stored count.");

    a_accept_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_status) |-> (o_stored_count != '0))
        else $error("Accepted value leaves the set empty.");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |=> !(q_empty))
        else $error("Request queue lost its contents while full.");

endmodule

// ===== bench/tb_bounded_set_min_gap_and_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bounded set with minimum gap and range
// Offers signed values through the request queue and checks every result
// against a table entry or a cycle-free model of the set that tracks the
// stored values, the running minimum and maximum, and the tightest gap. A
// short table covers the capacity corner cases. Random phases then raise and
// lower the capacity while the store fills, and close with the widest values
// and a duplicate. Both sides idle at random, and the result side holds off
// once for a long stretch so that the request queue fills up.
// ----------------------------------------------------------------------------
module tb_bounded_set_min_gap_and_range;
    import bsmg_pkg::*;

    localparam int MAX_ENTRIES   = 256;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int CLOSING_ITEMS = 400;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;

    localparam logic ACCEPTED = 1'b0;
    localparam logic REJECTED = 1'b1;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [VAL_W-1:0] data;
        bit               typed;
        t_result          want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             push;
    logic             full;
    logic [VAL_W-1:0] i_value;
    logic             empty;
    logic             pop;
    logic             o_status;
    logic             o_spans_valid;
    logic [VAL_W-1:0] o_shortest_span;
    logic [VAL_W-1:0] o_longest_span;
    logic [CNT_W-1:0] o_stored_count;

    logic [VAL_W-1:0] held_values [MAX_ENTRIES];
    int               held_count   = 0;
    logic [VAL_W-1:0] held_min     = '0;
    logic [VAL_W-1:0] held_max     = '0;
    logic [VAL_W-1:0] tightest_gap = GAP_RESET;
    int               cap_setting  = int'(CAP_RESET);

    t_result pending_results [$];
    t_row    plan [$];
    t_result head_result;
    int      errors    = 0;
    int      send_calm = 0;
    int      take_calm = 0;
    int      cycles    = 0;

    bounded_set_min_gap_and_range #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_value        (i_value),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_spans_valid  (o_spans_valid),
        .o_shortest_span(o_shortest_span),
        .o_longest_span (o_longest_span),
        .o_stored_count (o_stored_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int store_limit();
        return (cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : cap_setting;
    endfunction

    function automatic t_result insert_value(input logic [VAL_W-1:0] v);
        t_result          r;
        logic [VAL_W-1:0] d;
        r = '0;
        if (held_count >= store_limit()) begin
            r.status = REJECTED;
        end else begin
            r.status = ACCEPTED;
            for (int k = 0; k < held_count; k++) begin
                d = ($signed(v) < $signed(held_values[k])) ? held_values[k] - v
                                                           : v - held_values[k];
                if (d < tightest_gap) tightest_gap = d;
            end
            if (held_count == 0) begin
                held_min = v;
                held_max = v;
            end else begin
                if ($signed(v) < $signed(held_min)) held_min = v;
                if ($signed(v) > $signed(held_max)) held_max = v;
            end
            held_values[held_count] = v;
            held_count++;
        end
        r.stored_count = held_count[CNT_W-1:0];
        if (held_count >= 2) begin
            r.spans_valid   = 1'b1;
            r.shortest_span = tightest_gap;
            r.longest_span  = held_max - held_min;
        end
        return r;
    endfunction

    function automatic t_result make_result(input logic st, input logic sv,
                                            input logic [VAL_W-1:0] lo,
                                            input logic [VAL_W-1:0] hi,
                                            input logic [CNT_W-1:0] n);
        t_result r;
        r.status        = st;
        r.spans_valid   = sv;
        r.shortest_span = lo;
        r.longest_span  = hi;
        r.stored_count  = n;
        return r;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [VAL_W-1:0] data,
                                    input bit typed, input t_result want);
        t_row row;
        row.kind  = kind;
        row.data  = data;
        row.typed = typed;
        row.want  = want;
        plan.insert(plan.size(), row);
    endfunction

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(input bit closing, input int slot,
                                                    input logic [VAL_W-1:0] spread);
        logic [VAL_W-1:0] v;
        bit               clash;
        int               tries;
        if (held_count >= store_limit()) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return '0;
                    default: return '1;
                endcase
            end
            return $urandom;
        end
        if (closing) begin
            if (slot == 0) return 32'h8000_0000;
            if (slot == 1) return 32'h7FFF_FFFF;
            if (held_count > 0 && (slot == 2 || $urandom_range(0, 3) == 0))
                return held_values[$urandom_range(0, held_count - 1)];
            if (held_count > 0 && $urandom_range(0, 1) == 0)
                return held_values[$urandom_range(0, held_count - 1)]
                       + $urandom_range(0, 16) - 32'd8;
            return $urandom;
        end
        tries = 0;
        do begin
            if (held_count > 0 && $urandom_range(0, 2) == 0)
                v = held_values[$urandom_range(0, held_count - 1)]
                    + $urandom_range(0, 16) - 32'd8;
            else
                v = ($urandom & spread) - (spread >> 1);
            clash = 1'b0;
            for (int k = 0; k < held_count; k++)
                if (held_values[k] == v) clash = 1'b1;
            tries++;
        end while (clash && tries < 64);
        return v;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cap_setting = int'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_value(input logic [VAL_W-1:0] v, input bit typed,
                               input t_result want);
        int      gap;
        t_result predicted;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = insert_value(v);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("status", VAL_W'(head_result.status), VAL_W'(o_status));
                check_field("spans_valid", VAL_W'(head_result.spans_valid),
                            VAL_W'(o_spans_valid));
                check_field("shortest_span", head_result.shortest_span, o_shortest_span);
                check_field("longest_span", head_result.longest_span, o_longest_span);
                check_field("stored_count", VAL_W'(head_result.stored_count),
                            VAL_W'(o_stored_count));
            end
        end
    end

    initial begin
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(take_calm);
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int               phase;
        int               sent;
        int               length;
        int               bits;
        int               cap;
        int               grow;
        bit               closing;
        logic [VAL_W-1:0] spread;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        push        = 1'b0;
        pop         = 1'b0;
        i_value     = '0;

        // Capacity zero, then one, two and four, then lowered below the count, then 511.
        add_row(ROW_CFG, 32'd0, 1'b0, '0);
        add_row(ROW_ITEM, 32'h7FFF_FFFF, 1'b1,
                make_result(REJECTED, 1'b0, 32'd0, 32'd0, 9'd0));
        add_row(ROW_ITEM, 32'h8000_0000, 1'b1,
                make_result(REJECTED, 1'b0, 32'd0, 32'd0, 9'd0));
        add_row(ROW_CFG, 32'd1, 1'b0, '0);
        add_row(ROW_ITEM, 32'd100, 1'b1, make_result(ACCEPTED, 1'b0, 32'd0, 32'd0, 9'd1));
        add_row(ROW_ITEM, 32'd5, 1'b1, make_result(REJECTED, 1'b0, 32'd0, 32'd0, 9'd1));
        add_row(ROW_CFG, 32'd2, 1'b0, '0);
        add_row(ROW_ITEM, 32'd90, 1'b1, make_result(ACCEPTED, 1'b1, 32'd10, 32'd10, 9'd2));
        add_row(ROW_ITEM, 32'd90, 1'b1, make_result(REJECTED, 1'b1, 32'd10, 32'd10, 9'd2));
        add_row(ROW_CFG, 32'd4, 1'b0, '0);
        add_row(ROW_ITEM, 32'd103, 1'b1, make_result(ACCEPTED, 1'b1, 32'd3, 32'd13, 9'd3));
        add_row(ROW_ITEM, 32'hFFFF_FFFB, 1'b1,
                make_result(ACCEPTED, 1'b1, 32'd3, 32'd108, 9'd4));
        add_row(ROW_ITEM, 32'd0, 1'b1, make_result(REJECTED, 1'b1, 32'd3, 32'd108, 9'd4));
        add_row(ROW_CFG, 32'd2, 1'b0, '0);
        add_row(ROW_ITEM, 32'd7, 1'b1, make_result(REJECTED, 1'b1, 32'd3, 32'd108, 9'd4));
        add_row(ROW_CFG, 32'd511, 1'b0, '0);
        add_row(ROW_ITEM, 32'h0000_0070, 1'b0, '0);
        add_row(ROW_ITEM, 32'hFFFF_FF00, 1'b0, '0);
        add_row(ROW_ITEM, 32'h0000_0400, 1'b0, '0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_capacity(plan[i].data[CNT_W-1:0]);
            else
                offer_value(plan[i].data, plan[i].typed, plan[i].want);
        end

        // The spread of values widens phase by phase; the last phase stores the
        // widest values and a duplicate, and then fills the store.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            closing = (sent >= RANDOM_ITEMS - CLOSING_ITEMS);
            if (closing) begin
                cap    = $urandom_range(0, 1) ? 511 : MAX_ENTRIES;
                length = RANDOM_ITEMS - sent;
            end else begin
                case ($urandom_range(0, 9))
                    0: cap = 0;
                    1: cap = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
                    default: begin
                        grow = held_count + $urandom_range(1, 16);
                        cap  = (grow > MAX_ENTRIES) ? MAX_ENTRIES : grow;
                    end
                endcase
                length = $urandom_range(40, 120);
                if (length > RANDOM_ITEMS - CLOSING_ITEMS - sent)
                    length = RANDOM_ITEMS - CLOSING_ITEMS - sent;
            end
            write_capacity(cap[CNT_W-1:0]);
            bits   = (8 + phase > 30) ? 30 : 8 + phase;
            spread = (32'h1 << bits) - 32'h1;
            for (int n = 0; n < length; n++)
                offer_value(pick_value(closing, n, spread), 1'b0, '0);
            sent += length;
            phase++;
        end

        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
